>>> hdl/clsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package clsr_pkg;

	// Moduli, multipliers and fold constants (2^31 - modulus) of the two generators
	localparam logic [30:0] MOD1        = 31'd2147483563;
	localparam logic [30:0] MOD2        = 31'd2147483399;
	localparam logic [15:0] MUL1        = 16'd40014;
	localparam logic [15:0] MUL2        = 16'd40692;
	localparam logic [7:0]  FOLD1       = 8'd85;
	localparam logic [7:0]  FOLD2       = 8'd249;
	localparam logic [30:0] WRAP1       = 31'd2147483562;
	localparam logic [30:0] SEED2_RESET = 31'd123456789;

	// Generator steps discarded before the table fill on reseed
	localparam int WARMUP = 8;

	localparam int SHUFFLE_DEPTH_DEF = 32;

	// Commands
	localparam logic CMD_DRAW   = 1'b0;
	localparam logic CMD_RESEED = 1'b1;

	typedef logic [46:0] prod_t;

	// Reduce a (31 x 16)-bit product modulo m = 2^31 - c.
	// hi * 2^31 + lo == hi * c + lo (mod m); the sum stays below 2m.
	function automatic logic [30:0] fold_mod(input prod_t p, input logic [7:0] c,
			input logic [30:0] m);
		logic [31:0] x;
		x = 32'(p[46:31]) * 32'(c) + 32'(p[30:0]);
		if (x >= {1'b0, m}) begin
			x = x - {1'b0, m};
		end
		return x[30:0];
	endfunction

endpackage

`default_nettype wire

>>> hdl/clsr_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module clsr_ram #(
	parameter int WIDTH = 31,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/combined_lcg_shuffle_rng.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// command   start / busy         command, seed
// result    done (one cycle)     value
//
// A draw keeps busy high after the transfer while it multiplies, folds and
// reads the table on the shared multiply and fold unit; done rises as busy
// falls, and no command is taken before that. A reseed first steps the first
// generator SHUFFLE_DEPTH + 8 times, one multiply and fold each, then draws.
// Reset restores both generators, clears the last output and the table valid
// bits; the shuffle table reads as zero until written. done cannot be stalled.

module combined_lcg_shuffle_rng #(
	parameter int SHUFFLE_DEPTH = clsr_pkg::SHUFFLE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output      logic        busy,
	input  wire logic        command,
	input  wire logic [30:0] seed,
	output      logic        done,
	output      logic [30:0] value
);

	import clsr_pkg::*;

	localparam int SLOT_W = $clog2(SHUFFLE_DEPTH);
	localparam int CNT_W  = $clog2(SHUFFLE_DEPTH + WARMUP);
	localparam int EB_W   = SLOT_W + 31;

	// Bucket size and its reciprocal scaled by 2^31
	localparam logic [63:0] BUCKET_L = 64'd1 + 64'(WRAP1) / 64'(SHUFFLE_DEPTH);
	localparam logic [30:0] BUCKET   = 31'(BUCKET_L);
	localparam logic [SLOT_W:0] RECIP = (SLOT_W + 1)'((64'd1 << 31) / BUCKET_L);

	typedef enum logic [2:0] {
		S_IDLE,
		S_R_MUL,
		S_R_FOLD,
		S_D_MUL,
		S_D_FOLD,
		S_D_READ
	} state_t;

	state_t                state_q;
	logic [30:0]           gen1_q;
	logic [30:0]           gen2_q;
	logic [30:0]           last_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SHUFFLE_DEPTH-1:0] vld_q;

	prod_t                 p1_q;
	prod_t                 p2_q;
	logic [SLOT_W-1:0]     est_q;
	logic [SLOT_W-1:0]     slot_q;

	logic [30:0]           nxt1;
	logic [30:0]           nxt2;
	logic [SLOT_W+31:0]    est_prod;
	logic [EB_W-1:0]       est_b;
	logic [EB_W-1:0]       rem;
	logic [SLOT_W:0]       slot_wide;
	logic [SLOT_W-1:0]     slot;
	logic [30:0]           tbl;
	logic signed [31:0]    diff;
	logic [30:0]           draw_val;
	logic                  fill_we;
	logic                  ram_we;
	logic [SLOT_W-1:0]     ram_waddr;
	logic [30:0]           ram_wdata;
	logic                  ram_re;
	logic [30:0]           ram_rdata;

	assign busy = (state_q != S_IDLE);

	// Generator step results from the registered products
	assign nxt1 = fold_mod(p1_q, FOLD1, MOD1);
	assign nxt2 = fold_mod(p2_q, FOLD2, MOD2);

	// Slot estimate from the reciprocal, low by at most one
	assign est_prod = (SLOT_W + 32)'(last_q) * (SLOT_W + 32)'(RECIP);

	// Slot correction and guard against the last slot
	always_comb begin
		est_b     = EB_W'(est_q) * EB_W'(BUCKET);
		rem       = EB_W'(last_q) - est_b;
		slot_wide = (SLOT_W + 1)'(est_q) + (SLOT_W + 1)'(rem >= EB_W'(BUCKET));
		if (slot_wide >= (SLOT_W + 1)'(SHUFFLE_DEPTH)) begin
			slot = SLOT_W'(SHUFFLE_DEPTH - 1);
		end else begin
			slot = slot_wide[SLOT_W-1:0];
		end
	end

	// Entry minus second generator, wrapped into 1..WRAP1
	always_comb begin
		tbl  = vld_q[slot_q] ? ram_rdata : 31'd0;
		diff = $signed({1'b0, tbl}) - $signed({1'b0, gen2_q});
		if (diff < 32'sd1) begin
			draw_val = 31'(diff + $signed({1'b0, WRAP1}));
		end else begin
			draw_val = diff[30:0];
		end
	end

	// Table port: fill on reseed, refill on draw
	always_comb begin
		fill_we   = (state_q == S_R_FOLD) && (cnt_q < CNT_W'(SHUFFLE_DEPTH));
		ram_we    = fill_we || (state_q == S_D_READ);
		ram_re    = (state_q == S_D_FOLD);
		if (state_q == S_D_READ) begin
			ram_waddr = slot_q;
			ram_wdata = gen1_q;
		end else begin
			ram_waddr = cnt_q[SLOT_W-1:0];
			ram_wdata = nxt1;
		end
	end

	clsr_ram #(
		.WIDTH (31),
		.DEPTH (SHUFFLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (slot),
		.rdata (ram_rdata)
	);

	// Datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_R_MUL || state_q == S_D_MUL) begin
			p1_q <= prod_t'(gen1_q) * prod_t'(MUL1);
			p2_q <= prod_t'(gen2_q) * prod_t'(MUL2);
		end
		if (state_q == S_D_MUL) begin
			est_q <= est_prod[SLOT_W+30:31];
		end
		if (state_q == S_D_FOLD) begin
			slot_q <= slot;
		end
		if (state_q == S_D_READ) begin
			value <= draw_val;
		end
	end

	// Sequencer, generator state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			gen1_q  <= 31'd1;
			gen2_q  <= SEED2_RESET;
			last_q  <= 31'd0;
			cnt_q   <= '0;
			vld_q   <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (command == CMD_RESEED) begin
							gen1_q  <= (seed == 31'd0) ? 31'd1 : seed;
							gen2_q  <= (seed == 31'd0) ? 31'd1 : seed;
							cnt_q   <= CNT_W'(SHUFFLE_DEPTH + WARMUP - 1);
							state_q <= S_R_MUL;
						end else begin
							state_q <= S_D_MUL;
						end
					end
				end
				S_R_MUL: begin
					state_q <= S_R_FOLD;
				end
				S_R_FOLD: begin
					gen1_q <= nxt1;
					if (cnt_q == '0) begin
						last_q  <= nxt1;
						state_q <= S_D_MUL;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_R_MUL;
					end
				end
				S_D_MUL: begin
					state_q <= S_D_FOLD;
				end
				S_D_FOLD: begin
					gen1_q  <= nxt1;
					gen2_q  <= nxt2;
					state_q <= S_D_READ;
				end
				S_D_READ: begin
					last_q  <= draw_val;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> tb/combined_lcg_shuffle_rng_tb.sv
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_tb;

	// Generator constants, widened for the predictor arithmetic
	localparam int     DEPTH  = clsr_pkg::SHUFFLE_DEPTH_DEF;
	localparam int     WARM   = clsr_pkg::WARMUP;
	localparam longint M1     = longint'(clsr_pkg::MOD1);
	localparam longint A1     = longint'(clsr_pkg::MUL1);
	localparam longint Q1     = 53668;
	localparam longint R1     = 12211;
	localparam longint M2     = longint'(clsr_pkg::MOD2);
	localparam longint A2     = longint'(clsr_pkg::MUL2);
	localparam longint Q2     = 52774;
	localparam longint R2     = 3791;
	localparam longint WRAP   = longint'(clsr_pkg::WRAP1);
	localparam longint BUCKET = 1 + WRAP / DEPTH;
	localparam int     ITEMS_PER_PHASE = 380;

	// Predicts each drawn number and holds the ones still owed by the block
	class rng_scoreboard;
		longint gen1;
		longint gen2;
		longint last_out;
		longint slots[DEPTH];
		logic [30:0] pending_values[$];
		int mismatches;
		int draws;
		int reseeds;

		function new();
			gen1 = 1;
			gen2 = longint'(clsr_pkg::SEED2_RESET);
			last_out = 0;
			foreach (slots[i]) slots[i] = 0;
			mismatches = 0;
			draws = 0;
			reseeds = 0;
		endfunction

		// Schrage step: a*z mod m without overflowing 32 bits
		static function longint schrage_step(longint z, longint a, longint q, longint r,
				longint m);
			longint k;
			longint t;
			k = z / q;
			t = a * (z - k * q) - k * r;
			if (t < 0) t += m;
			return t;
		endfunction

		// Called on each accepted command transfer
		function void note_command(logic cmd, logic [30:0] s);
			longint z;
			longint slot;
			int j;
			if (cmd == clsr_pkg::CMD_RESEED) begin
				z = (s == 31'd0) ? 1 : longint'(s);
				gen1 = z;
				gen2 = z;
				// warm-up steps discarded, the rest fill the table top down
				for (j = DEPTH + WARM - 1; j >= 0; j--) begin
					gen1 = schrage_step(gen1, A1, Q1, R1, M1);
					if (j < DEPTH) slots[j] = gen1;
				end
				last_out = slots[0];
				reseeds++;
			end else begin
				draws++;
			end
			gen1 = schrage_step(gen1, A1, Q1, R1, M1);
			gen2 = schrage_step(gen2, A2, Q2, R2, M2);
			slot = last_out / BUCKET;
			if (slot < 0) slot = 0;
			if (slot >= DEPTH) slot = DEPTH - 1;
			last_out = slots[slot] - gen2;
			slots[slot] = gen1;
			if (last_out < 1) last_out += WRAP;
			pending_values.push_back(31'(last_out));
		endfunction

		// Called on each result transfer
		function void check_value(logic [30:0] v);
			logic [30:0] want;
			if (pending_values.size() == 0) begin
				$error("value: no result pending, actual %0d", v);
				mismatches++;
				return;
			end
			want = pending_values.pop_front();
			if (v !== want) begin
				$error("value mismatch: expected %0d, actual %0d", want, v);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic command = clsr_pkg::CMD_DRAW;
	logic [30:0] seed = 31'd0;
	logic busy;
	logic done;
	logic [30:0] value;

	rng_scoreboard sb = new();

	combined_lcg_shuffle_rng uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.seed(seed),
		.done(done),
		.value(value)
	);

	always #6 clk = ~clk;

	// Result monitor: done cannot be held off, so every strobe is a transfer
	always @(posedge clk) begin
		if (arst_n && done) sb.check_value(value);
	end

	// Each cycle the sender idles with the given chance; otherwise it raises start,
	// and the command transfers in a cycle in which busy is low
	task automatic send_command(input logic cmd, input logic [30:0] s, input int idle_pct);
		bit sent;
		sent = 1'b0;
		command <= cmd;
		seed <= s;
		while (!sent) begin
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
				@(posedge clk);
			end else begin
				start <= 1'b1;
				@(posedge clk);
				sent = !busy;
			end
		end
		sb.note_command(cmd, s);
	endtask

	// Seeds biased towards zero, the moduli and the top of the range
	function automatic logic [30:0] pick_seed();
		case ($urandom_range(9))
			0: return 31'($urandom_range(15));
			1: return clsr_pkg::MOD1 - 31'd8 + 31'($urandom_range(16));
			2: return clsr_pkg::MOD2 - 31'd8 + 31'($urandom_range(16));
			3: return 31'h7FFF_FFFF - 31'($urandom_range(3));
			default: return 31'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int n;
		int pct;
		logic cmd;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// draws on the reset state: zero table, slot 0
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'h7FFF_FFFF, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'h5555_5555, 0);
		// zero seed taken as one, then the smallest real seed
		send_command(clsr_pkg::CMD_RESEED, 31'd0, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'h2AAA_AAAA, 0);
		send_command(clsr_pkg::CMD_RESEED, 31'd1, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		// largest seed, above both moduli
		send_command(clsr_pkg::CMD_RESEED, 31'h7FFF_FFFF, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		// seed equal to the first modulus: first generator sticks at zero
		send_command(clsr_pkg::CMD_RESEED, clsr_pkg::MOD1, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		// seed equal to the second modulus: second generator sticks at zero
		send_command(clsr_pkg::CMD_RESEED, clsr_pkg::MOD2, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);
		// unreduced seeds just past the moduli, alternating bit patterns
		send_command(clsr_pkg::CMD_RESEED, clsr_pkg::MOD1 + 31'd1, 0);
		send_command(clsr_pkg::CMD_RESEED, clsr_pkg::MOD2 + 31'd1, 0);
		send_command(clsr_pkg::CMD_RESEED, 31'h5555_5555, 0);
		send_command(clsr_pkg::CMD_RESEED, 31'h2AAA_AAAA, 0);
		send_command(clsr_pkg::CMD_DRAW, 31'd0, 0);

		// random part: mostly draws, occasional reseeds
		for (phase = 0; phase < 3; phase++) begin
			pct = (phase == 0) ? 35 : (phase == 1) ? 88 : 0;
			for (n = 0; n < ITEMS_PER_PHASE; n++) begin
				cmd = ($urandom_range(99) < 8) ? clsr_pkg::CMD_RESEED : clsr_pkg::CMD_DRAW;
				send_command(cmd, pick_seed(), pct);
			end
		end
		start <= 1'b0;

		while (sb.pending_values.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);

		$display("Run covered %0d draws and %0d reseeds, edge seeds first,", sb.draws,
			sb.reseeds);
		$display("then random commands with the sender idling at 35, 88 and 0 percent.");
		if (sb.mismatches == 0 && sb.pending_values.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
